// ----- rtl/boot_header_crc_validator_macros.svh -----
// ---------------------------------------------------------------------------
// Boot header CRC validator: assertion macros
// Clocked on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BOOT_HEADER_CRC_VALIDATOR_MACROS_SVH
`define BOOT_HEADER_CRC_VALIDATOR_MACROS_SVH

// Same-cycle implication.
`define BHCV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("boot header validator: assertion failed");

// Next-cycle implication.
`define BHCV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("boot header validator: assertion failed");

`endif

// ----- rtl/bhcv_pkg.sv -----
// ---------------------------------------------------------------------------
// bhcv_pkg
// Shared constants, header layout and verdict codes of the boot header
// CRC validator.
// ---------------------------------------------------------------------------
package bhcv_pkg;

    localparam int HEADER_BYTES_DEF = 1024;

    localparam logic [31:0] MAGIC_VALUE = 32'h5441_4C50;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    // Byte offsets of the header layout
    localparam int OFF_MAGIC      = 0;
    localparam int OFF_VERSION    = 4;
    localparam int OFF_NAME_START = 8;
    localparam int OFF_NAME_END   = 72;
    localparam int OFF_BLOB       = 72;
    localparam int OFF_DRAM       = 88;
    localparam int OFF_CFG        = 96;
    localparam int NUM_WORDS      = 8;
    localparam int CRC_BYTES      = 4;

    typedef enum logic [2:0] {
        ERR_OK     = 3'd0,
        ERR_LENGTH = 3'd1,
        ERR_CRC    = 3'd2,
        ERR_MAGIC  = 3'd3,
        ERR_NAME   = 3'd4
    } t_err;

endpackage

// ----- rtl/bhcv_if.sv -----
// ---------------------------------------------------------------------------
// bhcv_in_if / bhcv_out_if
// Valid/ready channels for header bytes in and verdicts out.
// ---------------------------------------------------------------------------
interface bhcv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

interface bhcv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  error_code;
    logic [31:0] version;
    logic [31:0] blob_offset;
    logic [31:0] blob_size;
    logic [31:0] blob_type;
    logic [31:0] blob_checksum;
    logic [63:0] dram_bytes;
    logic [31:0] cfg_word1;
    logic [31:0] cfg_word2;
    logic [31:0] cfg_word3;
    logic [31:0] cfg_word4;

    modport source (output valid, output error_code, output version,
                    output blob_offset, output blob_size, output blob_type,
                    output blob_checksum, output dram_bytes, output cfg_word1,
                    output cfg_word2, output cfg_word3, output cfg_word4,
                    input ready);
    modport sink   (input valid, input error_code, input version,
                    input blob_offset, input blob_size, input blob_type,
                    input blob_checksum, input dram_bytes, input cfg_word1,
                    input cfg_word2, input cfg_word3, input cfg_word4,
                    output ready);
endinterface

// ----- rtl/boot_header_crc_validator.sv -----
// ---------------------------------------------------------------------------
// boot_header_crc_validator
// A byte is registered on entry and processed from the input register;
// the verdict for a last byte is loaded into the result register when that byte is processed.
// Throughput: one byte per cycle, set by the combinational byte CRC update;
// a last byte waits in the input register while the verdict slot is full.
// Reset: synchronous, active low; clears input and result valid, count, CRC
// and the name terminator flag.
// ---------------------------------------------------------------------------
`include "boot_header_crc_validator_macros.svh"

module boot_header_crc_validator
    import bhcv_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bhcv_in_if.sink     i_in,
    bhcv_out_if.source  o_out
);

    localparam int POS_W = $clog2(HEADER_BYTES + 2);
    localparam logic [POS_W-1:0] LP_HB       = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] LP_HB_SAT   = POS_W'(HEADER_BYTES + 1);
    localparam logic [POS_W-1:0] LP_CRC_BASE = POS_W'(HEADER_BYTES - CRC_BYTES);
    localparam logic [POS_W-1:0] LP_MAGIC    = POS_W'(OFF_MAGIC);
    localparam logic [POS_W-1:0] LP_VERSION  = POS_W'(OFF_VERSION);
    localparam logic [POS_W-1:0] LP_NAME_LO  = POS_W'(OFF_NAME_START);
    localparam logic [POS_W-1:0] LP_NAME_HI  = POS_W'(OFF_NAME_END);
    localparam logic [POS_W-1:0] LP_DRAM     = POS_W'(OFF_DRAM);

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_first;
    logic             r_in_last;

    // Running header state
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [31:0]      r_crc,    n_crc;
    logic             r_term,   n_term;
    logic [31:0]      r_stored, n_stored;
    logic [31:0]      r_magic,  n_magic;
    logic [31:0]      r_version, n_version;
    logic [31:0]      r_words [NUM_WORDS];
    logic [31:0]      n_words [NUM_WORDS];
    logic [63:0]      r_dram,   n_dram;

    // Result register
    logic             r_out_valid;
    t_err             r_out_err;
    logic [31:0]      r_out_version;
    logic [31:0]      r_out_words [NUM_WORDS];
    logic [63:0]      r_out_dram;

    logic             w_proc;
    logic [POS_W-1:0] w_pos;
    logic [31:0]      w_crc;
    logic [31:0]      w_crc_upd;
    logic [1:0]       w_crc_off;
    t_err             w_err;

    // Process the held byte unless it is a last byte and the result slot is full
    assign w_proc     = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
            r_in_last  <= i_in.last_byte;
        end
    end

    // First byte restarts count and CRC
    assign w_pos = r_in_first ? '0 : r_pos;
    assign w_crc = r_in_first ? CRC_INIT : r_crc;
    assign w_crc_off = 2'(w_pos - LP_CRC_BASE);

    bhcv_crc_byte u_crc (
        .i_crc  (w_crc),
        .i_byte (r_in_byte),
        .o_crc  (w_crc_upd)
    );

    always_comb begin
        logic [POS_W-1:0] base;
        n_magic   = r_magic;
        n_version = r_version;
        n_stored  = r_stored;
        n_dram    = r_dram;
        n_words   = r_words;
        base      = '0;

        n_crc = (w_pos < LP_CRC_BASE) ? w_crc_upd : w_crc;
        if (w_pos >= LP_CRC_BASE && w_pos < LP_HB) begin
            n_stored[{w_crc_off, 3'b000} +: 8] = r_in_byte;
        end

        if (w_pos >= LP_MAGIC && w_pos < LP_MAGIC + POS_W'(4)) begin
            n_magic[{w_pos[1:0], 3'b000} +: 8] = r_in_byte;
        end
        if (w_pos >= LP_VERSION && w_pos < LP_VERSION + POS_W'(4)) begin
            n_version[{w_pos[1:0], 3'b000} +: 8] = r_in_byte;
        end
        for (int i = 0; i < NUM_WORDS; i++) begin
            base = (i < NUM_WORDS / 2) ? POS_W'(OFF_BLOB + 4 * i)
                                       : POS_W'(OFF_CFG + 4 * (i - NUM_WORDS / 2));
            if (w_pos >= base && w_pos < base + POS_W'(4)) begin
                n_words[i][{w_pos[1:0], 3'b000} +: 8] = r_in_byte;
            end
        end
        if (w_pos >= LP_DRAM && w_pos < LP_DRAM + POS_W'(8)) begin
            n_dram[{w_pos[2:0], 3'b000} +: 8] = r_in_byte;
        end

        n_term = (r_in_first ? 1'b0 : r_term) ||
                 (w_pos >= LP_NAME_LO && w_pos < LP_NAME_HI && r_in_byte == 8'd0);
        n_pos  = (w_pos <= LP_HB) ? w_pos + POS_W'(1) : w_pos;
    end

    // Verdict, checks in priority order
    always_comb begin
        if (n_pos != LP_HB) begin
            w_err = ERR_LENGTH;
        end else if ((n_crc ^ CRC_INIT) != n_stored) begin
            w_err = ERR_CRC;
        end else if (n_magic != MAGIC_VALUE) begin
            w_err = ERR_MAGIC;
        end else if (!n_term) begin
            w_err = ERR_NAME;
        end else begin
            w_err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= CRC_INIT;
            r_term <= 1'b0;
        end else if (w_proc) begin
            if (r_in_last) begin
                r_pos  <= '0;
                r_crc  <= CRC_INIT;
                r_term <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_crc  <= n_crc;
                r_term <= n_term;
            end
        end
    end

    // Captured words are rewritten in full before any good verdict
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_stored  <= n_stored;
            r_magic   <= n_magic;
            r_version <= n_version;
            r_words   <= n_words;
            r_dram    <= n_dram;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_out_err <= w_err;
            if (w_err == ERR_OK) begin
                r_out_version <= n_version;
                r_out_words   <= n_words;
                r_out_dram    <= n_dram;
            end else begin
                r_out_version <= '0;
                r_out_dram    <= '0;
                for (int i = 0; i < NUM_WORDS; i++) begin
                    r_out_words[i] <= '0;
                end
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.error_code    = r_out_err;
    assign o_out.version       = r_out_version;
    assign o_out.blob_offset   = r_out_words[0];
    assign o_out.blob_size     = r_out_words[1];
    assign o_out.blob_type     = r_out_words[2];
    assign o_out.blob_checksum = r_out_words[3];
    assign o_out.dram_bytes    = r_out_dram;
    assign o_out.cfg_word1     = r_out_words[4];
    assign o_out.cfg_word2     = r_out_words[5];
    assign o_out.cfg_word3     = r_out_words[6];
    assign o_out.cfg_word4     = r_out_words[7];

    `BHCV_ASSERT_NOW(a_pos_saturates, 1'b1, r_pos <= LP_HB_SAT)
    `BHCV_ASSERT_NEXT(a_verdict_loads, w_proc && r_in_last, r_out_valid)
    `BHCV_ASSERT_NEXT(a_verdict_clears, w_proc && r_in_last, r_pos == '0 && r_crc == CRC_INIT && !r_term)
    `BHCV_ASSERT_NOW(a_error_zeroes, r_out_valid && r_out_err != ERR_OK, r_out_version == '0 && r_out_dram == '0)

endmodule

// ----- rtl/bhcv_crc_byte.sv -----
// ---------------------------------------------------------------------------
// bhcv_crc_byte
// One byte of a reflected CRC-32 update, eight bit steps in logic.
// ---------------------------------------------------------------------------
module bhcv_crc_byte
    import bhcv_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
        end
        o_crc = c;
    end

endmodule
